[sv/ffha_pkg.sv]
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and codes for the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_INIT  = 2'd2;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_NOFIT  = 2'd1;
    localparam logic [1:0] ST_NULL   = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [13:0] alloc_size;
        logic [12:0] block_address;
    } ffha_in_t;

    typedef struct packed {
        logic [12:0] address;
        logic [1:0]  status;
    } ffha_out_t;

    typedef enum logic [3:0] {
        OP_NOP, OP_LOAD, OP_INIT, OP_RD_B, OP_RD_NX, OP_CUR, OP_MARKF,
        OP_MERGE, OP_TAKE, OP_SPLIT, OP_ADV, OP_PUSH
    } dp_op_t;

    typedef enum logic [1:0] {
        RES_OK, RES_FAIL, RES_NULL, RES_ADDR
    } res_t;

    typedef struct packed {
        dp_op_t op;
        logic   res_load;
        res_t   res;
    } ffha_cmd_t;

    typedef struct packed {
        logic [1:0] act;
        logic       formatted;
        logic       addr_null;
        logic       free_out;
        logic       cur_merge;
        logic       rd_free;
        logic       fit;
        logic       split;
        logic       b_in;
        logic       out_busy;
    } ffha_sts_t;

endpackage

[sv/ffha_datapath.sv]
// ----------------------------------------------------------------------------
// ffha_datapath
// Header store, block walk registers, arena configuration and result register.
// ----------------------------------------------------------------------------
module ffha_datapath import ffha_pkg::*; #(
    parameter int ARENA_BYTES  = 8192,
    parameter int HEADER_BYTES = 17,
    parameter int MIN_CAPACITY = 24
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_valid,
    input  logic [13:0] cfg_data,
    input  ffha_in_t  s_data,
    input  ffha_cmd_t cmd,
    output ffha_sts_t sts,
    output logic      m_valid,
    input  logic      m_ready,
    output ffha_out_t m_data
);

    localparam int AW = $clog2(ARENA_BYTES);
    localparam int CW = AW + 1;
    localparam int WW = (AW + 2 > 16) ? AW + 2 : 16;
    localparam logic [WW-1:0] HDR   = WW'(HEADER_BYTES);
    localparam logic [WW-1:0] MINC  = WW'(MIN_CAPACITY);
    localparam logic [WW-1:0] ARENA = WW'(ARENA_BYTES);

    logic [CW:0]    mem_q [ARENA_BYTES];
    logic [CW:0]    rd_reg;
    ffha_in_t       in_reg;
    logic [WW-1:0]  b_reg, heap_end_reg;
    logic           formatted_reg;
    logic [13:0]    arena_reg;
    logic           cur_free_reg;
    logic [CW-1:0]  cur_cap_reg;
    res_t           res_reg;
    logic           out_valid_reg;
    ffha_out_t      out_reg;

    logic [WW-1:0]  q, nx, nb, n_clamp, cap_w, rd_cap_w, h_in, h_reg;
    logic           split;
    logic           we, re;
    logic [AW-1:0]  wa, ra;
    logic [CW:0]    wd;

    assign cap_w    = WW'(cur_cap_reg);
    assign rd_cap_w = WW'(rd_reg[CW-1:0]);
    assign q        = (WW'(in_reg.alloc_size) < MINC) ? MINC : WW'(in_reg.alloc_size);
    assign nx       = b_reg + HDR + cap_w;
    assign nb       = b_reg + HDR + q;
    assign split    = (q + HDR + MINC <= cap_w) && (nb < ARENA);
    assign h_in     = WW'(s_data.block_address) - HDR;
    assign h_reg    = WW'(in_reg.block_address) - HDR;

    always_comb begin
        n_clamp = WW'(arena_reg);
        if (n_clamp > ARENA) begin
            n_clamp = ARENA;
        end
        if (n_clamp < HDR) begin
            n_clamp = HDR;
        end
    end

    always_comb begin
        we = 1'b0;
        re = 1'b0;
        wa = b_reg[AW-1:0];
        ra = b_reg[AW-1:0];
        wd = {1'b1, rd_reg[CW-1:0]};
        case (cmd.op)
            OP_INIT: begin
                we = 1'b1;
                wa = '0;
                wd = {1'b1, CW'(n_clamp - HDR)};
            end
            OP_RD_B:  re = 1'b1;
            OP_RD_NX: begin
                re = 1'b1;
                ra = nx[AW-1:0];
            end
            OP_MARKF: we = 1'b1;
            OP_MERGE: begin
                we = 1'b1;
                wd = {1'b1, CW'(cap_w + HDR + rd_cap_w)};
            end
            OP_TAKE: begin
                we = 1'b1;
                wd = {1'b0, split ? CW'(q) : cur_cap_reg};
            end
            OP_SPLIT: begin
                we = 1'b1;
                wa = nb[AW-1:0];
                wd = {1'b1, CW'(cap_w - q - HDR)};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_q[wa] <= wd;
        end
        if (re) begin
            rd_reg <= mem_q[ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_end_reg  <= '0;
            formatted_reg <= 1'b0;
            arena_reg     <= 14'd8192;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                arena_reg <= cfg_data;
            end
            if (cmd.op == OP_INIT) begin
                heap_end_reg  <= n_clamp;
                formatted_reg <= 1'b1;
            end
            if (cmd.op == OP_PUSH) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                in_reg <= s_data;
                b_reg  <= (s_data.action == ACT_FREE) ? h_in : '0;
            end
            OP_CUR: begin
                cur_free_reg <= rd_reg[CW];
                cur_cap_reg  <= rd_reg[CW-1:0];
            end
            OP_MARKF: begin
                cur_free_reg <= 1'b1;
                cur_cap_reg  <= rd_reg[CW-1:0];
            end
            OP_MERGE: cur_cap_reg <= CW'(cap_w + HDR + rd_cap_w);
            OP_ADV:   b_reg <= nx;
            OP_PUSH: begin
                out_reg.address <= (res_reg == RES_ADDR) ? 13'(b_reg + HDR) : 13'd0;
                case (res_reg)
                    RES_FAIL: out_reg.status <= ST_NOFIT;
                    RES_NULL: out_reg.status <= ST_NULL;
                    default:  out_reg.status <= ST_DONE;
                endcase
            end
            default: ;
        endcase
        if (cmd.res_load) begin
            res_reg <= cmd.res;
        end
    end

    assign sts.act       = in_reg.action;
    assign sts.formatted = formatted_reg;
    assign sts.addr_null = (in_reg.block_address == 13'd0);
    assign sts.free_out  = (WW'(in_reg.block_address) < HDR) || (h_reg >= heap_end_reg);
    assign sts.cur_merge = cur_free_reg && (nx < heap_end_reg);
    assign sts.rd_free   = rd_reg[CW];
    assign sts.fit       = cur_free_reg && (cap_w >= q);
    assign sts.split     = split;
    assign sts.b_in      = (b_reg < heap_end_reg);
    assign sts.out_busy  = out_valid_reg;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

[sv/ffha_ctrl.sv]
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer for init, allocate walk with forward merging, and free.
// ----------------------------------------------------------------------------
module ffha_ctrl import ffha_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ffha_sts_t sts,
    output ffha_cmd_t cmd
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_DISP  = 10'b0000000010,
        S_CUR   = 10'b0000000100,
        S_FCUR  = 10'b0000001000,
        S_MRG   = 10'b0000010000,
        S_NX    = 10'b0000100000,
        S_FIT   = 10'b0001000000,
        S_SPLIT = 10'b0010000000,
        S_NEXT  = 10'b0100000000,
        S_RESP  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next   = state_reg;
        cmd.op       = OP_NOP;
        cmd.res_load = 1'b0;
        cmd.res      = RES_OK;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                cmd.res_load = 1'b1;
                state_next   = S_RESP;
                case (sts.act)
                    ACT_INIT: cmd.op = OP_INIT;
                    ACT_ALLOC: begin
                        if (!sts.formatted) begin
                            cmd.res = RES_FAIL;
                        end else begin
                            cmd.op     = OP_RD_B;
                            state_next = S_CUR;
                        end
                    end
                    ACT_FREE: begin
                        if (sts.addr_null) begin
                            cmd.res = RES_NULL;
                        end else if (sts.formatted && !sts.free_out) begin
                            cmd.op     = OP_RD_B;
                            state_next = S_FCUR;
                        end
                    end
                    default: ;
                endcase
            end
            S_CUR: begin
                cmd.op     = OP_CUR;
                state_next = S_MRG;
            end
            S_FCUR: begin
                cmd.op     = OP_MARKF;
                state_next = S_MRG;
            end
            S_MRG: begin
                if (sts.cur_merge) begin
                    cmd.op     = OP_RD_NX;
                    state_next = S_NX;
                end else begin
                    state_next = (sts.act == ACT_ALLOC) ? S_FIT : S_RESP;
                end
            end
            S_NX: begin
                if (sts.rd_free) begin
                    cmd.op     = OP_MERGE;
                    state_next = S_MRG;
                end else begin
                    state_next = (sts.act == ACT_ALLOC) ? S_FIT : S_RESP;
                end
            end
            S_FIT: begin
                if (sts.fit) begin
                    cmd.op       = OP_TAKE;
                    cmd.res_load = 1'b1;
                    cmd.res      = RES_ADDR;
                    state_next   = sts.split ? S_SPLIT : S_RESP;
                end else begin
                    cmd.op     = OP_ADV;
                    state_next = S_NEXT;
                end
            end
            S_SPLIT: begin
                cmd.op     = OP_SPLIT;
                state_next = S_RESP;
            end
            S_NEXT: begin
                if (sts.b_in) begin
                    cmd.op     = OP_RD_B;
                    state_next = S_CUR;
                end else begin
                    cmd.res_load = 1'b1;
                    cmd.res      = RES_FAIL;
                    state_next   = S_RESP;
                end
            end
            S_RESP: begin
                if (!sts.out_busy) begin
                    cmd.op     = OP_PUSH;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/first_fit_heap_allocator_top.sv]
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top
// First-fit heap allocator with forward coalescing over a single arena.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. Init, an unused action code, an
// allocate or free before init and the null or out-of-arena free cases go
// from dispatch straight to the result register. A free reads its header,
// marks it free, then reads each successor header and merges it while it
// is free and inside the heap. An allocate visits blocks from the arena
// start: a free block first merges its free successors the same way, then
// is taken if it fits (and split when room is left), else the walk moves on.
// A finished result waits in its own register while the next transaction is
// accepted. The header memory has no clearing pass.
module first_fit_heap_allocator_top import ffha_pkg::*; #(
    parameter int ARENA_BYTES  = 8192,
    parameter int HEADER_BYTES = 17,
    parameter int MIN_CAPACITY = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [13:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  ffha_in_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output ffha_out_t   m_data
);

    ffha_cmd_t cmd;
    ffha_sts_t sts;

    assign cfg_ready = 1'b1;

    ffha_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ffha_datapath #(
        .ARENA_BYTES  (ARENA_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .MIN_CAPACITY (MIN_CAPACITY)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready held after transaction accepted");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status != 2'd3)
        else $error("undefined status code");

    a_fail_null_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == ST_NOFIT || m_data.status == ST_NULL)
        |-> m_data.address == 13'd0)
        else $error("address on failed transaction");

    a_push_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_PUSH |-> !m_valid || m_ready)
        else $error("result overwritten before taken");

endmodule

[tb/first_fit_heap_allocator_top_test.sv]
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top_test
// Self-checking bench for the first-fit heap allocator.
// ----------------------------------------------------------------------------
// A short directed table runs first: requests before the arena is formatted,
// null and out-of-arena frees, an unused action code, exact fits and
// oversize requests. Random phases follow at several arena sizes, including
// the clamped extremes. Frees name only live blocks, null, or addresses
// outside the arena. Results are checked against the table or an in-bench
// allocator model. Both sides stall at random, except in the last phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module first_fit_heap_allocator_top_test;
    import ffha_pkg::*;

    localparam int ARENA_MAX = 8192;
    localparam int HDR_BYTES = 17;
    localparam int MIN_CAP   = 24;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  act;
        logic [13:0] size;
        logic [12:0] addr;
        bit          typed;
        logic [12:0] exp_addr;
        logic [1:0]  exp_status;
    } dir_row_t;

    localparam int N_DIR = 17;
    localparam dir_row_t DIR_TAB [N_DIR] = '{
        '{ACT_ALLOC,  14'd0,     13'd0,    1'b1, 13'd0,  ST_NOFIT},
        '{ACT_FREE,   14'd0,     13'd0,    1'b1, 13'd0,  ST_NULL},
        '{ACT_FREE,   14'd0,     13'd100,  1'b1, 13'd0,  ST_DONE},
        '{ACT_UNUSED, 14'd16383, 13'd8191, 1'b1, 13'd0,  ST_DONE},
        '{ACT_INIT,   14'd0,     13'd0,    1'b1, 13'd0,  ST_DONE},
        '{ACT_ALLOC,  14'd0,     13'd0,    1'b1, 13'd17, ST_DONE},
        '{ACT_ALLOC,  14'd8192,  13'd0,    1'b1, 13'd0,  ST_NOFIT},
        '{ACT_ALLOC,  14'd24,    13'd0,    1'b0, 13'd0,  ST_DONE},
        '{ACT_FREE,   14'd0,     13'd17,   1'b1, 13'd0,  ST_DONE},
        '{ACT_FREE,   14'd0,     13'd5,    1'b1, 13'd0,  ST_DONE},
        '{ACT_FREE,   14'd16383, 13'd0,    1'b1, 13'd0,  ST_NULL},
        '{ACT_ALLOC,  14'd8175,  13'd0,    1'b0, 13'd0,  ST_DONE},
        '{ACT_FREE,   14'd0,     13'd58,   1'b0, 13'd0,  ST_DONE},
        '{ACT_ALLOC,  14'd8175,  13'd0,    1'b0, 13'd0,  ST_DONE},
        '{ACT_FREE,   14'd0,     13'd17,   1'b0, 13'd0,  ST_DONE},
        '{ACT_ALLOC,  14'd8176,  13'd0,    1'b1, 13'd0,  ST_NOFIT},
        '{ACT_ALLOC,  14'd8175,  13'd0,    1'b0, 13'd0,  ST_DONE}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [13:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    ffha_in_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    ffha_out_t   m_data;

    first_fit_heap_allocator_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #5 aclk = ~aclk;

    // allocator model state
    int unsigned blk_cap  [ARENA_MAX];
    bit          blk_free [ARENA_MAX];
    int unsigned heap_end_m = 0;
    bit          fmt_m = 1'b0;
    int unsigned arena_cfg = 8192;
    int          live_addrs [$];

    ffha_out_t   alloc_results [$];
    int          errors = 0;
    int          n_items = 0;
    int          n_alloc_ok = 0;
    int          n_nofit = 0;
    int          n_frees = 0;
    int          n_results = 0;
    bit          quiet = 1'b0;

    function automatic void coalesce(int unsigned b);
        int unsigned nx;
        forever begin
            nx = b + HDR_BYTES + blk_cap[b];
            if (nx >= heap_end_m || !blk_free[b] || !blk_free[nx]) return;
            blk_cap[b] += HDR_BYTES + blk_cap[nx];
        end
    endfunction

    function automatic ffha_out_t heap_step(ffha_in_t it);
        ffha_out_t   r;
        int unsigned q, b, c, nb, h;
        r = '{address: '0, status: ST_DONE};
        case (it.action)
            ACT_INIT: begin
                c = arena_cfg;
                if (c > ARENA_MAX) c = ARENA_MAX;
                if (c < HDR_BYTES) c = HDR_BYTES;
                heap_end_m = c;
                blk_cap[0] = c - HDR_BYTES;
                blk_free[0] = 1'b1;
                fmt_m = 1'b1;
                live_addrs.delete();
            end
            ACT_ALLOC: begin
                q = (it.alloc_size < MIN_CAP) ? MIN_CAP : it.alloc_size;
                r.status = ST_NOFIT;
                b = 0;
                if (fmt_m) begin
                    while (b < heap_end_m) begin
                        coalesce(b);
                        if (blk_free[b] && blk_cap[b] >= q) begin
                            c = blk_cap[b];
                            if (q + HDR_BYTES + MIN_CAP <= c) begin
                                nb = b + HDR_BYTES + q;
                                if (nb < ARENA_MAX) begin
                                    blk_cap[b] = q;
                                    blk_cap[nb] = c - q - HDR_BYTES;
                                    blk_free[nb] = 1'b1;
                                end
                            end
                            blk_free[b] = 1'b0;
                            r.address = 13'(b + HDR_BYTES);
                            r.status = ST_DONE;
                            live_addrs.push_back(int'(b + HDR_BYTES));
                            break;
                        end
                        b = b + HDR_BYTES + blk_cap[b];
                    end
                end
            end
            ACT_FREE: begin
                if (it.block_address == 0) begin
                    r.status = ST_NULL;
                end else if (fmt_m && it.block_address >= HDR_BYTES) begin
                    h = it.block_address - HDR_BYTES;
                    if (h < heap_end_m) begin
                        blk_free[h] = 1'b1;
                        coalesce(h);
                    end
                    foreach (live_addrs[i])
                        if (live_addrs[i] == it.block_address) begin
                            live_addrs.delete(i);
                            break;
                        end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_item(ffha_in_t it, bit typed, ffha_out_t typed_res);
        ffha_out_t p;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        p = heap_step(it);
        alloc_results.push_back(typed ? typed_res : p);
        n_items++;
        if (it.action == ACT_ALLOC) begin
            if (p.status == ST_DONE) n_alloc_ok++;
            else n_nofit++;
        end
        if (it.action == ACT_FREE) n_frees++;
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        do @(posedge aclk); while (alloc_results.size() != 0);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_arena(logic [13:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        arena_cfg = 32'(v);
    endtask

    task automatic random_phase(int n);
        ffha_in_t    it;
        int          r;
        int unsigned he;
        for (int k = 0; k < n; k++) begin
            he = heap_end_m;
            it.alloc_size    = 14'($urandom_range(0, 16383));
            it.block_address = 13'($urandom_range(0, 8191));
            r = $urandom_range(0, 99);
            if (r < 85 && r >= 55 && live_addrs.size() == 0) r = 0;
            if (r < 55) begin
                it.action = ACT_ALLOC;
                if ($urandom_range(0, 9) == 0)
                    it.alloc_size = 14'($urandom_range(0, 8192));
                else
                    it.alloc_size = 14'($urandom_range(0, he / 4));
            end else if (r < 85) begin
                it.action = ACT_FREE;
                it.block_address =
                    13'(live_addrs[$urandom_range(0, live_addrs.size() - 1)]);
            end else if (r < 90) begin
                it.action = ACT_FREE;
                it.block_address = '0;
            end else if (r < 95) begin
                it.action = ACT_FREE;
                if (he + HDR_BYTES <= 8191 && $urandom_range(0, 1))
                    it.block_address = 13'($urandom_range(he + HDR_BYTES, 8191));
                else
                    it.block_address = 13'($urandom_range(1, HDR_BYTES - 1));
            end else if (r < 98) begin
                it.action = ACT_INIT;
            end else begin
                it.action = ACT_UNUSED;
            end
            send_item(it, 1'b0, '0);
        end
    endtask

    always @(posedge aclk) begin : result_check
        int stall;
        ffha_out_t e;
        if (quiet) begin
            m_ready <= 1'b1;
        end else if (stall > 0) begin
            stall--;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall = $urandom_range(0, 11);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (alloc_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected transaction, actual address %0d status %0d",
                         $time, m_data.address, m_data.status);
            end else begin
                e = alloc_results.pop_front();
                if (e.address !== m_data.address) begin
                    errors++;
                    $display("%0t: address mismatch, expected %0d actual %0d",
                             $time, e.address, m_data.address);
                end
                if (e.status !== m_data.status) begin
                    errors++;
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, e.status, m_data.status);
                end
            end
        end
    end

    initial begin
        #100ms;
        $display("status: fail");
        $finish;
    end

    initial begin
        static logic [13:0] arenas [9] = '{14'd64, 14'd0, 14'd16383, 14'd512, 14'd200,
                                           14'd1024, 14'd8192, 14'd300, 14'd2048};
        ffha_in_t  it;
        ffha_out_t tr;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIR_TAB[i]) begin
            it = '{action: DIR_TAB[i].act, alloc_size: DIR_TAB[i].size,
                   block_address: DIR_TAB[i].addr};
            tr = '{address: DIR_TAB[i].exp_addr, status: DIR_TAB[i].exp_status};
            send_item(it, DIR_TAB[i].typed, tr);
        end

        foreach (arenas[p]) begin
            drain();
            write_arena(arenas[p]);
            if (p == 8) quiet = 1'b1;
            send_item('{action: ACT_INIT, alloc_size: '0, block_address: '0}, 1'b0, '0);
            random_phase(205);
        end

        drain();
        repeat (50) @(posedge aclk);
        $display("%0d transactions, %0d results: %0d allocations granted, %0d refused,",
                 n_items, n_results, n_alloc_ok, n_nofit);
        $display("%0d frees, nine arena sizes from clamped minimum to clamped maximum",
                 n_frees);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
